// ===== rtl/core/rfpi_pkg.sv =====
`timescale 1ns / 1ps
package rfpi_pkg;
    localparam int unsigned RadW   = 12;
    localparam logic [RadW-1:0] RadReset = 12'd100;
    localparam int unsigned PosW   = 24;
    localparam int unsigned VelW   = 32;
    localparam int unsigned OffW   = 26;   // pointer*256 - pos, signed
    localparam int unsigned SqW    = 51;   // dx^2 + dy^2, unsigned
    localparam int unsigned RootW  = 26;   // floor(sqrt(s))
    localparam int unsigned SqrtSteps = 26;
    localparam int unsigned DivSteps  = 17;  // quotient in [0, 65536]
    localparam int unsigned R256W  = 20;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_REPEL   = 2'd1,
        CMD_ATTRACT = 2'd2,
        CMD_BOTH    = 2'd3
    } cmd_t;

    // Per-particle payload carried along the cell chain
    typedef struct packed {
        logic                    active;   // inside and one mode set
        logic                    repel;
        logic                    in_radius;
        logic signed [OffW-1:0]  dx;
        logic signed [OffW-1:0]  dy;
        logic signed [VelW-1:0]  vx;
        logic signed [VelW-1:0]  vy;
        logic [R256W-1:0]        r256;
    } item_t;

    // Square root cell state (bit-pair restoring method)
    typedef struct packed {
        logic [SqW-1:0]   rem;
        logic [RootW-1:0] root;
    } sqrt_t;

    // Divide cell state: restoring division of num by den
    typedef struct packed {
        logic [R256W+DivSteps-1:0] num;  // remaining dividend bits, msb first
        logic [R256W:0]            rem;
        logic [DivSteps-1:0]       quo;
    } div_t;
endpackage

// ===== rtl/core/rfpi_sqrt_cell.sv =====
`timescale 1ns / 1ps
module rfpi_sqrt_cell
    import rfpi_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  item_t item_in,
    input  logic  [SqW:0] rad_in,
    input  sqrt_t st_in,
    output item_t item_out,
    output logic  [SqW:0] rad_out,
    output sqrt_t st_out
);
    // One root bit: bring down two radicand bits, try (4*root+1)
    logic [SqW+1:0] rem_sh;
    logic [SqW+1:0] trial;
    sqrt_t          st_next;

    always_comb begin
        rem_sh = {st_in.rem, rad_in[SqW -: 2]};
        trial  = (SqW+2)'({st_in.root, 2'b01});
        if (rem_sh >= trial) begin
            st_next.rem  = SqW'(rem_sh - trial);
            st_next.root = {st_in.root[RootW-2:0], 1'b1};
        end else begin
            st_next.rem  = SqW'(rem_sh);
            st_next.root = {st_in.root[RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_out <= item_in;
            rad_out  <= {rad_in[SqW-2:0], 2'b00};
            st_out   <= st_next;
        end
    end
endmodule

// ===== rtl/core/rfpi_div_cell.sv =====
`timescale 1ns / 1ps
module rfpi_div_cell
    import rfpi_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  item_t item_in,
    input  div_t  st_in,
    output item_t item_out,
    output div_t  st_out
);
    // One quotient bit of a restoring divide by r256
    localparam int unsigned NumW = R256W + DivSteps;
    logic [R256W+1:0] rem_sh;
    div_t             st_next;

    always_comb begin
        rem_sh = {st_in.rem, st_in.num[NumW-1]};
        st_next.num = {st_in.num[NumW-2:0], 1'b0};
        if (rem_sh >= {2'b00, item_in.r256}) begin
            st_next.rem = (R256W+1)'(rem_sh - {2'b00, item_in.r256});
            st_next.quo = {st_in.quo[DivSteps-2:0], 1'b1};
        end else begin
            st_next.rem = (R256W+1)'(rem_sh);
            st_next.quo = {st_in.quo[DivSteps-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_out <= item_in;
            st_out   <= st_next;
        end
    end
endmodule

// ===== rtl/core/radial_falloff_particle_impulse_core.sv =====
`timescale 1ns / 1ps
// Pipeline from input transfer to result valid: 3 front stages,
//   26 square root cells, 17 divide cells, 3 back stages.
// Throughput: one particle per cycle; the whole chain advances together and
//   stalls only while the output register holds an untaken result.
// Reset: aresetn synchronous active low clears valid bits and sets the
//   influence radius to 100.
module radial_falloff_particle_impulse_core
    import rfpi_pkg::*;
#(
    parameter logic [RadW-1:0] RadiusReset = RadReset
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [RadW-1:0] cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // tdata: pointer_x[11:0], pointer_y[23:12], pos_x[47:24], pos_y[71:48],
    //        vel_x[103:72], vel_y[135:104]
    input  logic [135:0]  s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // tdata: new_vel_x[31:0], new_vel_y[63:32], inside_radius[64],
    //        saturated[65], zero fill
    output logic [71:0]   m_tdata
);
    localparam int unsigned Depth = 3 + SqrtSteps + DivSteps + 3;

    logic [RadW-1:0] radius_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) radius_reg <= RadiusReset;
        else if (cfg_we) radius_reg <= cfg_wdata;
    end

    // Valid line for the whole chain; advance when output slot is free
    logic [Depth-1:0] vld_reg;
    logic             en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[Depth-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[Depth-2:0], s_tvalid};
    end

    // Front stage 1: offsets
    item_t a_reg;
    logic  [1:0] cmd_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg.dx <= OffW'({2'b00, s_tdata[11:0], 8'h00}) -
                        OffW'($signed(s_tdata[24 +: PosW]));
            a_reg.dy <= OffW'({2'b00, s_tdata[23:12], 8'h00}) -
                        OffW'($signed(s_tdata[48 +: PosW]));
            a_reg.vx <= s_tdata[103:72];
            a_reg.vy <= s_tdata[135:104];
            a_reg.r256 <= {radius_reg, 8'h00};
            a_reg.active    <= 1'b0;
            a_reg.repel     <= 1'b0;
            a_reg.in_radius <= 1'b0;
            cmd_reg <= s_tuser;
        end
    end

    // Front stage 2: squares
    item_t b_reg;
    logic [SqW-2:0] sqx_reg, sqy_reg;
    logic [39:0]    rsq_reg;
    logic [1:0]     cmd_b_reg;
    logic signed [2*OffW-1:0] dsq_x, dsq_y;
    assign dsq_x = a_reg.dx * a_reg.dx;
    assign dsq_y = a_reg.dy * a_reg.dy;
    always_ff @(posedge aclk) begin
        if (en) begin
            b_reg     <= a_reg;
            sqx_reg   <= dsq_x[SqW-2:0];
            sqy_reg   <= dsq_y[SqW-2:0];
            rsq_reg   <= a_reg.r256 * a_reg.r256;
            cmd_b_reg <= cmd_reg;
        end
    end

    // Front stage 3: sum and radius compare
    item_t c_reg;
    item_t c_next;
    logic [SqW-1:0] s_reg;
    logic [SqW-1:0] s_sum;
    logic           ins;
    assign s_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign ins   = s_sum < {11'd0, rsq_reg};
    always_comb begin
        c_next           = b_reg;
        c_next.in_radius = ins;
        c_next.active    = ins && (cmd_b_reg == CMD_REPEL || cmd_b_reg == CMD_ATTRACT);
        c_next.repel     = cmd_b_reg == CMD_REPEL;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= c_next;
            s_reg <= s_sum;
        end
    end

    // Square root chain; radicand padded to an even bit count
    item_t           sq_item [SqrtSteps+1];
    logic [SqW:0]    sq_rad  [SqrtSteps+1];
    sqrt_t           sq_st   [SqrtSteps+1];
    assign sq_item[0] = c_reg;
    assign sq_rad[0]  = {1'b0, s_reg};
    assign sq_st[0]   = '0;

    for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
        rfpi_sqrt_cell u_cell (
            .aclk(aclk), .en(en), .item_in(sq_item[i]),
            .rad_in(sq_rad[i]),
            .st_in(sq_st[i]), .item_out(sq_item[i+1]),
            .rad_out(sq_rad[i+1]), .st_out(sq_st[i+1])
        );
    end

    // Divide chain: ((r256 - d) << 16) / r256
    item_t dv_item [DivSteps+1];
    div_t  dv_st   [DivSteps+1];
    logic [R256W-1:0] diff;
    assign diff = sq_item[SqrtSteps].r256 - R256W'(sq_st[SqrtSteps].root);
    assign dv_item[0] = sq_item[SqrtSteps];
    // quotient <= 65536 so the first bits of the dividend give zero; the 17
    // steps consume diff<<16 starting with rem preloaded by diff>>1
    assign dv_st[0].num = {diff[0], 16'h0000, {R256W{1'b0}}};
    assign dv_st[0].rem = {2'b00, diff[R256W-1:1]};
    assign dv_st[0].quo = '0;

    for (genvar j = 0; j < DivSteps; j++) begin : g_div
        rfpi_div_cell u_cell (
            .aclk(aclk), .en(en), .item_in(dv_item[j]), .st_in(dv_st[j]),
            .item_out(dv_item[j+1]), .st_out(dv_st[j+1])
        );
    end

    // Back stage 1: f = min(65535, r*r >> 16)
    item_t e_reg;
    logic [15:0] f_reg;
    logic [33:0] rr;
    assign rr = dv_st[DivSteps].quo * dv_st[DivSteps].quo;
    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg <= dv_item[DivSteps];
            f_reg <= rr[33:32] != 2'b00 ? 16'hFFFF : rr[31:16];
        end
    end

    // Back stage 2: offset * f; stage 3 takes floor(product / 256) as delta
    item_t g_reg;
    logic signed [OffW+16:0] px_reg, py_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            g_reg  <= e_reg;
            px_reg <= e_reg.dx * $signed({1'b0, f_reg});
            py_reg <= e_reg.dy * $signed({1'b0, f_reg});
        end
    end

    // Back stage 3: add or subtract, then clamp
    logic signed [OffW+9:0] ddx, ddy;
    logic signed [OffW+10:0] sx, sy;
    logic signed [VelW-1:0] nx, ny;
    logic sat_x, sat_y;
    assign ddx = (OffW+10)'(px_reg >>> 8);
    assign ddy = (OffW+10)'(py_reg >>> 8);
    assign sx = g_reg.repel ? (OffW+11)'(g_reg.vx) - (OffW+11)'(ddx)
                            : (OffW+11)'(g_reg.vx) + (OffW+11)'(ddx);
    assign sy = g_reg.repel ? (OffW+11)'(g_reg.vy) - (OffW+11)'(ddy)
                            : (OffW+11)'(g_reg.vy) + (OffW+11)'(ddy);
    always_comb begin
        sat_x = 1'b0;
        sat_y = 1'b0;
        nx = g_reg.vx;
        ny = g_reg.vy;
        if (g_reg.active) begin
            if (sx > 37'sh07FFFFFFF) begin nx = 32'h7FFFFFFF; sat_x = 1'b1; end
            else if (sx < -37'sh080000000) begin nx = 32'h80000000; sat_x = 1'b1; end
            else nx = VelW'(sx);
            if (sy > 37'sh07FFFFFFF) begin ny = 32'h7FFFFFFF; sat_y = 1'b1; end
            else if (sy < -37'sh080000000) begin ny = 32'h80000000; sat_y = 1'b1; end
            else ny = VelW'(sy);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) m_tdata <= {6'd0, sat_x | sat_y, g_reg.in_radius, ny, nx};
    end

`ifndef ASSERT_OFF
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready mismatch");
    a_sat_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[65] || m_tdata[64])
        else $error("saturation outside radius");
`endif
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import rfpi_pkg::*;

    localparam int unsigned LATENCY   = 49;
    localparam int unsigned IDLE_MAX  = 20000;
    localparam int unsigned RAND_ITEMS = 1750;

    // Expected result of one particle update
    typedef struct packed {
        logic        saturated;
        logic        in_radius;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
    } impulse_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_we = 1'b0;
    logic [RadW-1:0] cfg_wdata = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [135:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [71:0]   m_tdata;

    logic [RadW-1:0] radius_model;
    impulse_t        impulse_q[$];
    int unsigned     n_errors = 0;
    int unsigned     idle_cycles = 0;
    bit              stim_done = 1'b0;

    radial_falloff_particle_impulse_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_vel(longint v, ref logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Velocity update for one particle under the current radius
    function automatic impulse_t predict_impulse(cmd_t cmd, logic [11:0] ptr_x,
            logic [11:0] ptr_y, logic signed [23:0] pos_x, logic signed [23:0] pos_y,
            logic signed [31:0] vel_x, logic signed [31:0] vel_y);
        impulse_t res;
        longint dx, dy, nx, ny, ddx, ddy;
        longint unsigned s, r256, d, r, f;
        logic sat;
        sat = 1'b0;
        dx = longint'(ptr_x) * 256 - longint'(pos_x);
        dy = longint'(ptr_y) * 256 - longint'(pos_y);
        s = dx * dx + dy * dy;
        r256 = longint'(radius_model) * 256;
        nx = vel_x;
        ny = vel_y;
        res.in_radius = s < r256 * r256;
        if (res.in_radius && (cmd == CMD_REPEL || cmd == CMD_ATTRACT)) begin
            d = root_floor(s);
            r = ((r256 - d) << 16) / r256;
            f = (r * r) >> 16;
            if (f > 65535) f = 65535;
            // arithmetic shift floors toward minus infinity
            ddx = (dx * longint'(f)) >>> 8;
            ddy = (dy * longint'(f)) >>> 8;
            if (cmd == CMD_REPEL) begin
                nx = nx - ddx;
                ny = ny - ddy;
            end else begin
                nx = nx + ddx;
                ny = ny + ddy;
            end
            nx = clamp_vel(nx, sat);
            ny = clamp_vel(ny, sat);
        end
        res.vel_x = nx[31:0];
        res.vel_y = ny[31:0];
        res.saturated = sat;
        return res;
    endfunction

    function automatic int unsigned gap_len();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    // Send one particle; prediction is made at the transfer
    task automatic send_particle(cmd_t cmd, logic [11:0] ptr_x, logic [11:0] ptr_y,
            logic [23:0] pos_x, logic [23:0] pos_y, logic [31:0] vel_x, logic [31:0] vel_y);
        int unsigned g;
        g = gap_len();
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {vel_y, vel_x, pos_y, pos_x, ptr_y, ptr_x};
        do @(posedge aclk); while (!s_tready);
        impulse_q.push_back(predict_impulse(cmd, ptr_x, ptr_y, pos_x, pos_y, vel_x, vel_y));
        @(negedge aclk);
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (impulse_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic set_radius(logic [RadW-1:0] rad);
        drain_pipe();
        cfg_we    <= 1'b1;
        cfg_wdata <= rad;
        @(negedge aclk);
        cfg_we <= 1'b0;
        radius_model = rad;
    endtask

    // Position near a pointer, in Q15.8, offset within +-span pixels
    function automatic logic [23:0] near_pos(logic [11:0] ptr, int unsigned span);
        longint p;
        p = longint'(ptr) * 256 + $signed($urandom_range(2 * span * 256)) - span * 256;
        return p[23:0];
    endfunction

    task automatic test_directed();
        send_particle(CMD_REPEL, 12'd50, 12'd50, 24'd12800, 24'd12800, 32'd0, 32'd0);
        send_particle(CMD_ATTRACT, 12'd50, 12'd50, 24'd12800, 24'd12800, 32'd7, -32'sd7);
        send_particle(CMD_REPEL, 12'd50, 12'd50, 24'd12000, 24'd13000, 32'd100, 32'd5);
        send_particle(CMD_ATTRACT, 12'd50, 12'd50, 24'd12000, 24'd13000, 32'd100, 32'd5);
        send_particle(CMD_NONE, 12'd50, 12'd50, 24'd12000, 24'd13000, 32'd100, 32'd5);
        send_particle(CMD_BOTH, 12'd50, 12'd50, 24'd12000, 24'd13000, 32'd100, 32'd5);
        // outside radius
        send_particle(CMD_REPEL, 12'd4095, 12'd4095, 24'h800000, 24'h800000,
                      32'h7fffffff, 32'h80000000);
        send_particle(CMD_ATTRACT, 12'd0, 12'd0, 24'h7fffff, 24'h7fffff, 32'hffffffff, 32'd0);
        // saturation at the velocity extremes
        send_particle(CMD_REPEL, 12'd50, 12'd50, 24'd12000, 24'd12000,
                      32'h80000000, 32'h80000000);
        send_particle(CMD_ATTRACT, 12'd50, 12'd50, 24'd12000, 24'd12000,
                      32'h7fffffff, 32'h7fffffff);
        send_particle(CMD_REPEL, 12'd50, 12'd50, 24'd13600, 24'd13600,
                      32'h7fffffff, 32'h7fffffff);
        // offsets of one radius on both axes lie outside
        send_particle(CMD_REPEL, 12'd200, 12'd200, 24'd25600, 24'd76800, 32'd0, 32'd0);
        send_particle(CMD_REPEL, 12'd200, 12'd200, 24'd25600, 24'd76799, 32'd0, 32'd0);
    endtask

    task automatic test_radius_extremes();
        set_radius(12'd1);
        send_particle(CMD_REPEL, 12'd10, 12'd10, 24'd2560, 24'd2560, 32'd3, 32'd3);
        send_particle(CMD_ATTRACT, 12'd10, 12'd10, 24'd2600, 24'd2500, 32'd3, 32'd3);
        send_particle(CMD_REPEL, 12'd10, 12'd10, 24'd2816, 24'd2560, 32'd3, 32'd3);
        set_radius(12'd4095);
        send_particle(CMD_REPEL, 12'd4095, 12'd4095, 24'h800000, 24'h800000,
                      32'h80000000, 32'h7fffffff);
        send_particle(CMD_ATTRACT, 12'd4095, 12'd0, 24'h800000, 24'h7fffff,
                      32'h7fffffff, 32'h80000000);
        send_particle(CMD_ATTRACT, 12'd2048, 12'd2048, 24'h000000, 24'h000000,
                      32'h12345678, 32'hedcba987);
    endtask

    task automatic test_random(int unsigned count);
        logic [11:0] px, py;
        logic [23:0] xx, yy;
        cmd_t cmd;
        for (int unsigned i = 0; i < count; i++) begin
            px = 12'($urandom);
            py = 12'($urandom);
            cmd = cmd_t'($urandom_range(9) < 8 ? $urandom_range(2, 1) : $urandom_range(3));
            if ($urandom_range(9) < 8) begin
                xx = near_pos(px, radius_model + 1);
                yy = near_pos(py, radius_model + 1);
            end else begin
                xx = 24'($urandom);
                yy = 24'($urandom);
            end
            send_particle(cmd, px, py, xx, yy,
                          $urandom_range(3) == 0 ? {$urandom_range(1) ? 16'h7fff : 16'h8000,
                                                    16'($urandom)} : 32'($urandom),
                          $urandom_range(3) == 0 ? {$urandom_range(1) ? 16'h7fff : 16'h8000,
                                                    16'($urandom)} : 32'($urandom));
        end
    endtask

    // Result checking
    always @(posedge aclk) begin
        impulse_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[65:0];
            if (impulse_q.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                n_errors++;
            end else begin
                want = impulse_q.pop_front();
                if (got.vel_x !== want.vel_x) begin
                    $error("new_vel_x expected %h got %h", want.vel_x, got.vel_x);
                    n_errors++;
                end
                if (got.vel_y !== want.vel_y) begin
                    $error("new_vel_y expected %h got %h", want.vel_y, got.vel_y);
                    n_errors++;
                end
                if (got.in_radius !== want.in_radius) begin
                    $error("inside_radius expected %b got %b", want.in_radius, got.in_radius);
                    n_errors++;
                end
                if (got.saturated !== want.saturated) begin
                    $error("saturated expected %b got %b", want.saturated, got.saturated);
                    n_errors++;
                end
            end
        end
    end

    // Receiver stalls
    initial begin
        int unsigned g;
        forever begin
            @(negedge aclk);
            m_tready <= 1'b1;
            g = gap_len();
            if (g != 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end
        end
    end

    // Watchdog on cycles without any transfer
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || stim_done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("radial_falloff_particle_impulse_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int unsigned waited;
        radius_model = RadReset;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_radius_extremes();
        set_radius(12'd100);
        test_random(RAND_ITEMS / 3);
        set_radius(12'd7);
        test_random(RAND_ITEMS / 3);
        set_radius(12'($urandom_range(4095, 1)));
        test_random(RAND_ITEMS / 3);
        s_tvalid <= 1'b0;
        waited = 0;
        while (impulse_q.size() != 0 && waited < IDLE_MAX) begin
            @(negedge aclk);
            waited++;
        end
        stim_done = 1'b1;
        repeat (LATENCY + 4) @(negedge aclk);
        if (impulse_q.size() != 0) begin
            $error("%0d results never arrived", impulse_q.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("radial_falloff_particle_impulse_core: match");
        else
            $display("radial_falloff_particle_impulse_core: mismatch");
        $finish;
    end
endmodule
